// File: design/kmtf_pkg.sv
// Package of shared types and codes for the keyed table with merge and move-to-front.
package kmtf_pkg;

    // Result status codes, as they appear on the status field of a result beat.
    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_MOVED    = 3'd2,
        ST_FIRST    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // Request type codes on the req_type field.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // Fixed payload widths of the channels.
    localparam int unsigned KEY_FIELD_BITS    = 16;
    localparam int unsigned THREAD_FIELD_BITS = 16;
    localparam int unsigned STATUS_BITS       = 3;
    localparam int unsigned POS_BITS          = 4;

endpackage

// File: design/kmtf_if.sv
// Valid/ready channel interfaces for request and result beats.
interface kmtf_req_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        req_type;
    logic [kmtf_pkg::KEY_FIELD_BITS-1:0]         proc_key;
    logic [kmtf_pkg::THREAD_FIELD_BITS-1:0]      thread_add;

    modport source (output valid, output req_type, output proc_key, output thread_add,
                    input ready);
    modport sink   (input valid, input req_type, input proc_key, input thread_add,
                    output ready);
endinterface

interface kmtf_res_if;
    logic                                        valid;
    logic                                        ready;
    logic [kmtf_pkg::STATUS_BITS-1:0]            status;
    logic [kmtf_pkg::POS_BITS-1:0]               position;
    logic [kmtf_pkg::THREAD_FIELD_BITS-1:0]      thread_total;

    modport source (output valid, output status, output position, output thread_total,
                    input ready);
    modport sink   (input valid, input status, input position, input thread_total,
                    output ready);
endinterface

// File: design/kmtf_ram.sv
// Table storage: one write port and one read port with registered read data.
module kmtf_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/kmtf_unit.sv
// Shared key compare and saturating thread-count adder.
module kmtf_unit #(
    parameter int unsigned KEY_BITS   = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic [KEY_BITS-1:0]                      i_key_a,
    input  logic [KEY_BITS-1:0]                      i_key_b,
    input  logic [COUNT_BITS-1:0]                    i_count,
    input  logic [kmtf_pkg::THREAD_FIELD_BITS-1:0]   i_add,
    output logic                                     o_key_eq,
    output logic [COUNT_BITS-1:0]                    o_sum
);
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    logic [32:0] w_sum;
    logic [32:0] w_sat;

    assign o_key_eq = (i_key_a == i_key_b);

    // The sum clamps at the largest count the table can hold.
    assign w_sum = {1'b0, 32'(i_count)} + {17'b0, i_add};
    assign w_sat = (w_sum > COUNT_MAX) ? COUNT_MAX : w_sum;
    assign o_sum = w_sat[COUNT_BITS-1:0];
endmodule

// File: design/keyed_table_merge_move_to_front.sv
// Top level of the keyed thread-count table with merge on add and move-to-front.
//
//  Channel   Dir  Payload                              Beat taken when
//  i_req     in   req_type, proc_key, thread_add       valid && ready
//  o_res     out  status, position, thread_total       valid && ready
//
//  One request at a time is worked by a small sequencer around one shared compare
//  and add unit and a single table memory with one read and one write port.
//  The search reads one entry and compares it in the next cycle. A move of index k above
//  zero then moves each entry from k-1 to the head one place toward the tail, reading it
//  and writing it back, and last writes the moved entry at the head.
//  Reset clears the sequencer, the fill count and the result valid; the memory is not
//  cleared, because the search never reads past the fill count.
//  A finished result waits in its output register; the next request is accepted while
//  it waits and is held at its end until the result register is free.
module keyed_table_merge_move_to_front #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned KEY_BITS    = 16,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmtf_req_if.sink      i_req,
    kmtf_res_if.source    o_res
);
    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned WW = KEY_BITS + COUNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_HIT,
        S_MISS,
        S_SHRD,
        S_SHWR,
        S_HEAD,
        S_EMIT
    } t_state;

    t_state r_state;

    // Latched request.
    logic                                      r_req;
    logic [KEY_BITS-1:0]                       r_key;
    logic [kmtf_pkg::THREAD_FIELD_BITS-1:0]    r_add;

    logic [IW-1:0]                             r_idx;
    logic [CW-1:0]                             r_count;

    // Entry carried to the head during a move.
    logic [KEY_BITS-1:0]                       r_mk;
    logic [COUNT_BITS-1:0]                     r_mt;

    // Result waiting to be loaded into the output register.
    kmtf_pkg::t_status                         r_res_st;
    logic [kmtf_pkg::POS_BITS-1:0]             r_res_pos;
    logic [COUNT_BITS-1:0]                     r_res_tot;

    // Output register.
    logic                                      r_out_valid;
    logic [kmtf_pkg::STATUS_BITS-1:0]          r_out_st;
    logic [kmtf_pkg::POS_BITS-1:0]             r_out_pos;
    logic [kmtf_pkg::THREAD_FIELD_BITS-1:0]    r_out_tot;

    // Memory port signals.
    logic                                      w_we;
    logic [IW-1:0]                             w_waddr;
    logic [WW-1:0]                             w_wdata;
    logic                                      w_re;
    logic [IW-1:0]                             w_raddr;
    logic [WW-1:0]                             w_rdata;

    logic [KEY_BITS-1:0]                       w_rd_key;
    logic [COUNT_BITS-1:0]                     w_rd_thr;
    logic [COUNT_BITS-1:0]                     w_unit_cnt;
    logic                                      w_key_eq;
    logic [COUNT_BITS-1:0]                     w_sum;

    logic                                      w_in_take;
    logic                                      w_out_free;
    logic [31:0]                               w_key_ext;
    logic [31:0]                               w_idx_ext;
    logic [31:0]                               w_cnt_ext;
    logic [31:0]                               w_tot_ext;

    assign w_rd_key = w_rdata[WW-1:COUNT_BITS];
    assign w_rd_thr = w_rdata[COUNT_BITS-1:0];

    // Keys compare in their low KEY_BITS bits; a key field narrower than KEY_BITS is zero extended.
    assign w_key_ext = {16'b0, i_req.proc_key};
    assign w_idx_ext = 32'(r_idx);
    assign w_cnt_ext = 32'(r_count);
    assign w_tot_ext = 32'(r_res_tot);

    assign w_in_take  = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    assign i_req.ready = (r_state == S_IDLE);

    // A merge adds to the stored count; a new entry adds to zero, which only clamps.
    assign w_unit_cnt = (r_state == S_HIT) ? w_rd_thr : '0;

    kmtf_unit #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .i_key_a  (w_rd_key),
        .i_key_b  (r_key),
        .i_count  (w_unit_cnt),
        .i_add    (r_add),
        .o_key_eq (w_key_eq),
        .o_sum    (w_sum)
    );

    kmtf_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Memory port control follows the sequencer state.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_idx;
        case (r_state)
            S_RD: begin
                w_re = 1'b1;
            end
            S_HIT: begin
                // A merge rewrites the hit entry with its new count.
                w_we    = (r_req == kmtf_pkg::REQ_ADD);
                w_wdata = {w_rd_key, w_sum};
            end
            S_MISS: begin
                w_we    = (r_req == kmtf_pkg::REQ_ADD) && (w_cnt_ext < TABLE_DEPTH);
                w_waddr = r_count[IW-1:0];
                w_wdata = {r_key, w_sum};
            end
            S_SHRD: begin
                w_re    = 1'b1;
                w_raddr = r_idx - IW'(1);
            end
            S_SHWR: begin
                w_we = 1'b1;
            end
            S_HEAD: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {r_mk, r_mt};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // While emitting, the load below decides the valid bit on its own.
            if (r_out_valid && o_res.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_req   <= i_req.req_type;
                        r_key   <= w_key_ext[KEY_BITS-1:0];
                        r_add   <= i_req.thread_add;
                        r_idx   <= '0;
                        r_state <= (r_count == '0) ? S_MISS : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_key_eq) begin
                        r_state <= S_HIT;
                    end else if (w_idx_ext + 32'd1 == w_cnt_ext) begin
                        r_state <= S_MISS;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_RD;
                    end
                end
                S_HIT: begin
                    r_res_pos <= w_idx_ext[kmtf_pkg::POS_BITS-1:0];
                    if (r_req == kmtf_pkg::REQ_ADD) begin
                        r_res_st  <= kmtf_pkg::ST_MERGED;
                        r_res_tot <= w_sum;
                        r_state   <= S_EMIT;
                    end else if (r_idx == '0) begin
                        r_res_st  <= kmtf_pkg::ST_FIRST;
                        r_res_tot <= w_rd_thr;
                        r_state   <= S_EMIT;
                    end else begin
                        r_res_st  <= kmtf_pkg::ST_MOVED;
                        r_res_tot <= w_rd_thr;
                        r_mk      <= w_rd_key;
                        r_mt      <= w_rd_thr;
                        r_state   <= S_SHRD;
                    end
                end
                S_MISS: begin
                    if (r_req == kmtf_pkg::REQ_MOVE) begin
                        r_res_st  <= kmtf_pkg::ST_NOTFOUND;
                        r_res_pos <= '0;
                        r_res_tot <= '0;
                    end else if (w_cnt_ext < TABLE_DEPTH) begin
                        r_res_st  <= kmtf_pkg::ST_APPENDED;
                        r_res_pos <= w_cnt_ext[kmtf_pkg::POS_BITS-1:0];
                        r_res_tot <= w_sum;
                        r_count   <= r_count + CW'(1);
                    end else begin
                        r_res_st  <= kmtf_pkg::ST_FULL;
                        r_res_pos <= '0;
                        r_res_tot <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_SHRD: begin
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    // The entry one place nearer the head has been written here.
                    r_idx   <= r_idx - IW'(1);
                    r_state <= (r_idx == IW'(1)) ? S_HEAD : S_SHRD;
                end
                S_HEAD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_res_st;
                        r_out_pos   <= r_res_pos;
                        r_out_tot   <= w_tot_ext[kmtf_pkg::THREAD_FIELD_BITS-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_st;
    assign o_res.position     = r_out_pos;
    assign o_res.thread_total = r_out_tot;
endmodule

// File: design/kmtf_checker.sv
// Port-level checker for the keyed table, bound to the top level.
module kmtf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [3:0]  i_position,
    input logic [15:0] i_thread_total
);
    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_position) && $stable(i_thread_total))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= kmtf_pkg::ST_FULL)
        else $error("status code out of range");

    // A full table or an absent key reports no position and no count.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == kmtf_pkg::ST_FULL || i_status == kmtf_pkg::ST_NOTFOUND)
            |-> i_position == 4'd0 && i_thread_total == 16'd0)
        else $error("full or not-found result carries data");

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == kmtf_pkg::ST_FIRST |-> i_position == 4'd0)
        else $error("already-first result not at position zero");
endmodule

bind keyed_table_merge_move_to_front kmtf_checker u_kmtf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_position     (o_res.position),
    .i_thread_total (o_res.thread_total)
);

// File: tb/kmtf_table_checker.sv
// Scoreboard for the keyed thread table: predicts every result beat and checks each field.
`timescale 1ns / 1ps

module kmtf_table_checker #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kmtf_req_if  i_req,
    kmtf_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int unsigned KW = kmtf_pkg::KEY_FIELD_BITS;
    localparam int unsigned TW = kmtf_pkg::THREAD_FIELD_BITS;
    localparam int unsigned PW = kmtf_pkg::POS_BITS;

    localparam logic [TW-1:0] THREAD_MAX = '1;

    typedef struct packed {
        kmtf_pkg::t_status  status;
        logic [PW-1:0]      position;
        logic [TW-1:0]      thread_total;
    } t_table_result;

    // Shadow copy of the table, kept in step with accepted request beats.
    logic [KW-1:0]  shadow_key     [TABLE_DEPTH];
    logic [TW-1:0]  shadow_threads [TABLE_DEPTH];
    int unsigned    shadow_fill;

    t_table_result awaited_results[$];

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic t_table_result table_step(input logic req_type,
                                                 input logic [KW-1:0] key,
                                                 input logic [TW-1:0] add);
        t_table_result  res;
        int             hit;
        logic [TW:0]    sum;
        logic [KW-1:0]  moved_key;
        logic [TW-1:0]  moved_threads;
        res = '{status: kmtf_pkg::ST_NOTFOUND, position: '0, thread_total: '0};
        hit = -1;
        for (int i = 0; i < int'(shadow_fill); i++) begin
            if (hit < 0 && shadow_key[i] == key) begin
                hit = i;
            end
        end
        if (req_type == kmtf_pkg::REQ_ADD) begin
            if (hit >= 0) begin
                sum = {1'b0, shadow_threads[hit]} + {1'b0, add};
                shadow_threads[hit] = sum[TW] ? THREAD_MAX : sum[TW-1:0];
                res.status       = kmtf_pkg::ST_MERGED;
                res.position     = PW'(hit);
                res.thread_total = shadow_threads[hit];
            end else if (shadow_fill < TABLE_DEPTH) begin
                shadow_key[shadow_fill]     = key;
                shadow_threads[shadow_fill] = add;
                res.status       = kmtf_pkg::ST_APPENDED;
                res.position     = PW'(shadow_fill);
                res.thread_total = add;
                shadow_fill++;
            end else begin
                res.status = kmtf_pkg::ST_FULL;
            end
        end else begin
            if (hit == 0) begin
                res.status       = kmtf_pkg::ST_FIRST;
                res.thread_total = shadow_threads[0];
            end else if (hit > 0) begin
                moved_key     = shadow_key[hit];
                moved_threads = shadow_threads[hit];
                for (int i = hit; i > 0; i--) begin
                    shadow_key[i]     = shadow_key[i-1];
                    shadow_threads[i] = shadow_threads[i-1];
                end
                shadow_key[0]     = moved_key;
                shadow_threads[0] = moved_threads;
                res.status       = kmtf_pkg::ST_MOVED;
                res.position     = PW'(hit);
                res.thread_total = moved_threads;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            shadow_fill  = 0;
            o_fail_count = 0;
            awaited_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing outstanding: status %0d position %0d %s %0d",
                           i_res.status, i_res.position, "total", i_res.thread_total);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res.status);
                        o_fail_count++;
                    end
                    if (i_res.position !== want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, i_res.position);
                        o_fail_count++;
                    end
                    if (i_res.thread_total !== want.thread_total) begin
                        $error("thread_total mismatch: expected %0d, actual %0d",
                               want.thread_total, i_res.thread_total);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_results.push_back(table_step(i_req.req_type, i_req.proc_key,
                                                     i_req.thread_add));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: tb/tb_keyed_table_merge_move_to_front.sv
// Top of the testbench: clock, reset, request and result traffic, and the final verdict.
`timescale 1ns / 1ps

module tb_keyed_table_merge_move_to_front;

    // The slowest request is a move of the last entry; the drain after the last result
    // is meant to cover any beat still in flight.
    localparam int unsigned DRAIN_CYCLES  = 100;
    // The run makes 425 requests; the limit is taken several times over the time their
    // worst correct case needs, stalls included.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned KW            = kmtf_pkg::KEY_FIELD_BITS;
    localparam int unsigned TW            = kmtf_pkg::THREAD_FIELD_BITS;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    // Percent chances of the sender sitting idle before a beat and of the
    // receiver holding ready low in a cycle.
    int   send_idle_pct = 0;
    int   stall_pct     = 0;

    // Keys placed in the table by the directed part; the table never shrinks,
    // so these stay the full set of resident keys for the rest of the run.
    logic [KW-1:0] resident_keys [TABLE_ENTRIES];

    kmtf_req_if req_if ();
    kmtf_res_if res_if ();

    keyed_table_merge_move_to_front u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    kmtf_table_checker #(
        .TABLE_DEPTH (TABLE_ENTRIES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops beats.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random; a zero percentage leaves ready high throughout.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Presents one request beat and returns at the edge where it was taken.
    // Ready is sampled at the falling edge: inputs only move at rising edges, so
    // the value seen there is the one the block uses at the next rising edge.
    // Valid stays high on return, so a following beat can go out back to back.
    task automatic offer_request(input logic rtype, input logic [KW-1:0] key,
                                 input logic [TW-1:0] add);
        logic taken;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= rtype;
        req_if.proc_key   <= key;
        req_if.thread_add <= add;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = req_if.ready;
            @(posedge clk);
        end
    endtask

    // Random traffic against a full table: mostly merges and moves of resident
    // keys with random counts, plus unknown keys that must come back as full or
    // not found. Additions are mostly small so that not every count saturates.
    task automatic random_request();
        int             pick;
        logic [TW-1:0]  add;
        pick = $urandom_range(0, 99);
        add  = ($urandom_range(0, 19) == 0) ? TW'($urandom) : TW'($urandom_range(0, 15));
        if (pick < 45) begin
            offer_request(kmtf_pkg::REQ_ADD,
                          resident_keys[$urandom_range(0, TABLE_ENTRIES-1)], add);
        end else if (pick < 60) begin
            offer_request(kmtf_pkg::REQ_ADD, KW'($urandom), TW'($urandom));
        end else if (pick < 92) begin
            offer_request(kmtf_pkg::REQ_MOVE,
                          resident_keys[$urandom_range(0, TABLE_ENTRIES-1)], add);
        end else begin
            offer_request(kmtf_pkg::REQ_MOVE, KW'($urandom), TW'($urandom));
        end
    endtask

    initial begin
        req_if.valid      <= 1'b0;
        req_if.req_type   <= kmtf_pkg::REQ_ADD;
        req_if.proc_key   <= '0;
        req_if.thread_add <= '0;
        rst_n             <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        resident_keys[0] = 16'h0000;
        resident_keys[1] = 16'hFFFF;
        for (int i = 1; i <= 14; i++) begin
            resident_keys[i+1] = KW'(i * 16'h1111);
        end

        // Directed part, with neither side idling.
        // A move on the empty table must report not found.
        offer_request(kmtf_pkg::REQ_MOVE, 16'h0000, 16'h0000);
        // The all-zero and all-ones keys and counts go in as new entries.
        offer_request(kmtf_pkg::REQ_ADD, 16'h0000, 16'h0000);
        offer_request(kmtf_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF);
        // A merge past the top of the count saturates; one landing exactly on it does not wrap.
        offer_request(kmtf_pkg::REQ_ADD, 16'hFFFF, 16'h0001);
        offer_request(kmtf_pkg::REQ_ADD, 16'h0000, 16'hFFFF);
        // Moving the head is a no-op; moving the second entry swaps the pair.
        offer_request(kmtf_pkg::REQ_MOVE, 16'h0000, 16'h1234);
        offer_request(kmtf_pkg::REQ_MOVE, 16'hFFFF, 16'h0000);
        // An absent key on a non-empty table.
        offer_request(kmtf_pkg::REQ_MOVE, 16'hABCD, 16'h0000);
        // Fill the table to its last slot.
        for (int i = 1; i <= 14; i++) begin
            offer_request(kmtf_pkg::REQ_ADD, resident_keys[i+1], TW'(i));
        end
        // A new key on a full table is refused and leaves it unchanged.
        offer_request(kmtf_pkg::REQ_ADD, 16'hABCD, 16'h0005);
        // The tail entry travels all the way to the head, then merges there.
        offer_request(kmtf_pkg::REQ_MOVE, resident_keys[TABLE_ENTRIES-1], 16'h0000);
        offer_request(kmtf_pkg::REQ_ADD, resident_keys[TABLE_ENTRIES-1], 16'h0003);

        // Random part, one phase per idling pattern.
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
        end
        send_idle_pct = 61;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
        end
        send_idle_pct = 0;
        stall_pct    <= 61;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
        end
        send_idle_pct = 20;
        stall_pct    <= 20;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
        end
        req_if.valid <= 1'b0;

        // Let every outstanding result come back, then watch a while longer for
        // stray beats; the cycle limit covers a block that never answers.
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
